### hdl/bqo_pkg.sv
package bqo_pkg;

    // storage defaults
    localparam int DEPTH     = 16;
    localparam int WORD_BITS = 32;

    // field widths fixed by the interface
    localparam int OPCODE_BITS    = 3;
    localparam int FIELD5_BITS    = 5;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 5;

    // reset values of the configuration registers
    localparam logic [FIELD5_BITS-1:0] FILL_LIMIT_RESET = 5'd16;
    localparam logic                   OVERWRITE_RESET  = 1'b0;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FILL_LIMIT = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_OVERWRITE  = 2'd1;

    // operation codes
    typedef enum logic [OPCODE_BITS-1:0] {
        OP_PUSH     = 3'd0,
        OP_POP_ONE  = 3'd1,
        OP_POP_MANY = 3'd2,
        OP_PEEK     = 3'd3,
        OP_TRY_POP  = 3'd4,
        OP_NEWEST   = 3'd5
    } opcode_t;

    // one input item
    typedef struct packed {
        logic [OPCODE_BITS-1:0] opcode;
        logic [WORD_BITS-1:0]   word;
        logic [FIELD5_BITS-1:0] number;
    } in_item_t;

    // one result item
    typedef struct packed {
        logic [WORD_BITS-1:0]   data;
        logic                   ok;
        logic [FIELD5_BITS-1:0] level;
        logic [FIELD5_BITS-1:0] evicted;
    } out_item_t;

    // status of one finished operation, handed from the core to the top level
    typedef struct packed {
        logic                   hit;
        logic                   ok;
        logic [FIELD5_BITS-1:0] level;
        logic [FIELD5_BITS-1:0] evicted;
    } op_status_t;

endpackage

### hdl/bqo_ram.sv
module bqo_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/bqo_core.sv
module bqo_core #(
    parameter  int DEPTH = bqo_pkg::DEPTH,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    input  bqo_pkg::in_item_t                  item,
    input  logic [bqo_pkg::FIELD5_BITS-1:0]    fill_limit,
    input  logic                               overwrite_oldest,
    output logic                               ram_we,
    output logic [AW-1:0]                      ram_waddr,
    output logic [bqo_pkg::WORD_BITS-1:0]      ram_wdata,
    output logic                               ram_re,
    output logic [AW-1:0]                      ram_raddr,
    output logic                               done,
    output bqo_pkg::op_status_t                status
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > bqo_pkg::FIELD5_BITS) ? CW : bqo_pkg::FIELD5_BITS;
    localparam int SW = LW + 1;

    logic [AW-1:0] head_reg;
    logic [AW-1:0] head_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          done_reg;
    bqo_pkg::op_status_t status_reg;
    bqo_pkg::op_status_t status_next;

    logic [LW-1:0] cnt_w;
    logic [LW-1:0] lim_w;
    logic [LW-1:0] num_w;
    logic [LW-1:0] depth_w;
    logic [LW-1:0] ev_w;
    logic [LW-1:0] c1_w;
    logic [LW-1:0] lvl_w;
    logic [AW-1:0] h1;
    logic          full;
    logic          evict;
    logic          store;

    // ring index wrap, valid for sums below twice the depth
    function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
        logic [SW-1:0] t;
        t = s;
        if (t >= SW'(DEPTH))
        begin
            t = t - SW'(DEPTH);
        end
        return t[AW-1:0];
    endfunction

    // widened operands for compares
    assign cnt_w   = LW'(count_reg);
    assign lim_w   = LW'(fill_limit);
    assign num_w   = LW'(item.number);
    assign depth_w = LW'(DEPTH);

    // push policy: evict the oldest or drop the new word when at the limit
    assign full  = (cnt_w >= lim_w);
    assign evict = full && overwrite_oldest;
    assign ev_w  = cnt_w - lim_w + LW'(1);
    assign h1    = evict ? wrap(SW'(head_reg) + SW'(ev_w)) : head_reg;
    assign c1_w  = evict ? (lim_w - LW'(1)) : cnt_w;
    assign store = !(full && !overwrite_oldest) && (c1_w < depth_w);

    // next state, memory access and result status
    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        ram_we      = 1'b0;
        ram_waddr   = wrap(SW'(h1) + SW'(c1_w));
        ram_wdata   = item.word;
        ram_re      = 1'b0;
        ram_raddr   = head_reg;
        status_next = '0;
        if (item_valid)
        begin
            case (item.opcode)
                bqo_pkg::OP_PUSH:
                begin
                    if (lim_w == '0)
                    begin
                        if (overwrite_oldest)
                        begin
                            status_next.evicted = cnt_w[bqo_pkg::FIELD5_BITS-1:0];
                            head_next  = wrap(SW'(head_reg) + SW'(cnt_w));
                            count_next = '0;
                        end
                    end
                    else
                    begin
                        if (evict)
                        begin
                            status_next.evicted = ev_w[bqo_pkg::FIELD5_BITS-1:0];
                            head_next  = h1;
                            count_next = CW'(c1_w);
                        end
                        if (store)
                        begin
                            ram_we         = 1'b1;
                            count_next     = CW'(c1_w + LW'(1));
                            status_next.ok = 1'b1;
                        end
                    end
                end
                bqo_pkg::OP_POP_ONE:
                begin
                    if (cnt_w != '0)
                    begin
                        head_next  = wrap(SW'(head_reg) + SW'(1));
                        count_next = count_reg - CW'(1);
                    end
                end
                bqo_pkg::OP_POP_MANY:
                begin
                    if (num_w != '0 && num_w <= cnt_w)
                    begin
                        head_next      = wrap(SW'(head_reg) + SW'(num_w));
                        count_next     = CW'(cnt_w - num_w);
                        status_next.ok = 1'b1;
                    end
                end
                bqo_pkg::OP_PEEK:
                begin
                    if (num_w < cnt_w)
                    begin
                        ram_re          = 1'b1;
                        ram_raddr       = wrap(SW'(head_reg) + SW'(num_w));
                        status_next.ok  = 1'b1;
                        status_next.hit = 1'b1;
                    end
                end
                bqo_pkg::OP_TRY_POP:
                begin
                    if (cnt_w != '0)
                    begin
                        ram_re          = 1'b1;
                        head_next       = wrap(SW'(head_reg) + SW'(1));
                        count_next      = count_reg - CW'(1);
                        status_next.ok  = 1'b1;
                        status_next.hit = 1'b1;
                    end
                end
                bqo_pkg::OP_NEWEST:
                begin
                    if (cnt_w != '0)
                    begin
                        ram_re          = 1'b1;
                        ram_raddr       = wrap(SW'(head_reg) + SW'(cnt_w) - SW'(1));
                        status_next.ok  = 1'b1;
                        status_next.hit = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
        lvl_w             = LW'(count_next);
        status_next.level = lvl_w[bqo_pkg::FIELD5_BITS-1:0];
    end

    // queue pointers and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            done_reg  <= item_valid;
        end
    end

    // result status register
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
    end

    assign done   = done_reg;
    assign status = status_reg;

endmodule

### hdl/bounded_queue_with_overwrite.sv
// Bounded FIFO of data words with a programmable fill limit and full policy.
// Operations: push, pop one, pop many, peek at an offset, try pop, read newest.
// Command channel: an item is accepted at a clock edge with start high; busy
// is always low, so a new item can be issued in every cycle.
// Result channel: each item gives one result, shown on result for exactly one
// cycle while done is high. The result passes the input register, then the
// ring store read and result register, after the accepting edge; throughput
// is one item per cycle, since every operation is a fixed amount of pointer
// work plus at most one ring store access, a write for a push or a read for
// a peek, try pop or read newest.
// The receiver cannot stall, so no result is ever held back.
// Configuration: cfg_index 0 writes fill_limit, 1 writes overwrite_oldest
// (bit 0); cfg_ready is always high. Write only while no item is in flight.
// Reset clears the queue to empty and loads fill_limit 16 and overwrite off;
// the ring store itself is not cleared, since only held entries are read.
module bounded_queue_with_overwrite #(
    parameter int DEPTH = bqo_pkg::DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  bqo_pkg::in_item_t                   item,
    output logic                                done,
    output bqo_pkg::out_item_t                  result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bqo_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [bqo_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                                item_valid_reg;
    bqo_pkg::in_item_t                   item_reg;
    logic [bqo_pkg::FIELD5_BITS-1:0]     fill_limit_reg;
    logic                                overwrite_reg;
    logic                                ram_we;
    logic [AW-1:0]                       ram_waddr;
    logic [bqo_pkg::WORD_BITS-1:0]       ram_wdata;
    logic                                ram_re;
    logic [AW-1:0]                       ram_raddr;
    logic [bqo_pkg::WORD_BITS-1:0]       ram_rdata;
    bqo_pkg::op_status_t                 status;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // input item register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            item_reg <= item;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_limit_reg <= bqo_pkg::FILL_LIMIT_RESET;
            overwrite_reg  <= bqo_pkg::OVERWRITE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bqo_pkg::CFG_FILL_LIMIT: fill_limit_reg <= cfg_data;
                bqo_pkg::CFG_OVERWRITE:  overwrite_reg  <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // queue control
    bqo_core #(
        .DEPTH (DEPTH)
    ) u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (item_valid_reg),
        .item             (item_reg),
        .fill_limit       (fill_limit_reg),
        .overwrite_oldest (overwrite_reg),
        .ram_we           (ram_we),
        .ram_waddr        (ram_waddr),
        .ram_wdata        (ram_wdata),
        .ram_re           (ram_re),
        .ram_raddr        (ram_raddr),
        .done             (done),
        .status           (status)
    );

    // ring store
    bqo_ram #(
        .WIDTH (bqo_pkg::WORD_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // result assembly, data only on a read hit
    assign result.data    = status.hit ? ram_rdata : '0;
    assign result.ok      = status.ok;
    assign result.level   = status.level;
    assign result.evicted = status.evicted;

endmodule

### tb/queue_checker.sv
`timescale 1ns / 100ps

module queue_checker
    import bqo_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       busy,
    input  in_item_t   item,
    input  logic       done,
    input  out_item_t  result,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output int         pending,
    output int         failures
);

    localparam int MAX_REPORTS = 10;

    // shadow copy of the queue contents and its settings
    logic [WORD_BITS-1:0] ring [DEPTH];
    int unsigned          head;
    int unsigned          count;
    int unsigned          limit;
    logic                 overwrite;

    // results still owed by the block, oldest first
    out_item_t            awaited_results [$];
    out_item_t            oldest;
    int                   results_seen;

    // remove up to n of the oldest entries
    function automatic void drop_oldest(input int unsigned n);
        if (n > count)
            n = count;
        head  = (head + n) % DEPTH;
        count = count - n;
    endfunction

    // apply one operation to the shadow queue and return its result
    function automatic out_item_t apply_queue_op(input in_item_t op_item);
        out_item_t   res;
        int unsigned num;
        int unsigned excess;
        logic        room;
        res  = '0;
        num  = 32'(op_item.number);
        room = 1'b1;
        case (op_item.opcode)
            OP_PUSH:
            begin
                if (limit == 0)
                begin
                    // zero limit: overwrite flushes everything, the word never lands
                    if (overwrite)
                    begin
                        res.evicted = FIELD5_BITS'(count);
                        drop_oldest(count);
                    end
                end
                else
                begin
                    if (count >= limit)
                    begin
                        if (overwrite)
                        begin
                            excess      = count - limit + 1;
                            res.evicted = FIELD5_BITS'(excess);
                            drop_oldest(excess);
                        end
                        else
                            room = 1'b0;
                    end
                    // a limit above the store size still cannot exceed it
                    if (room && count < DEPTH)
                    begin
                        ring[(head + count) % DEPTH] = op_item.word;
                        count  = count + 1;
                        res.ok = 1'b1;
                    end
                end
            end
            OP_POP_ONE:
            begin
                if (count > 0)
                    drop_oldest(1);
            end
            OP_POP_MANY:
            begin
                if (num != 0 && num <= count)
                begin
                    drop_oldest(num);
                    res.ok = 1'b1;
                end
            end
            OP_PEEK:
            begin
                if (num < count)
                begin
                    res.data = ring[(head + num) % DEPTH];
                    res.ok   = 1'b1;
                end
            end
            OP_TRY_POP:
            begin
                if (count > 0)
                begin
                    res.data = ring[head];
                    res.ok   = 1'b1;
                    drop_oldest(1);
                end
            end
            OP_NEWEST:
            begin
                if (count > 0)
                begin
                    res.data = ring[(head + count - 1) % DEPTH];
                    res.ok   = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        res.level = FIELD5_BITS'(count);
        return res;
    endfunction

    // watch the three channels at each edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head      = 0;
            count     = 0;
            limit     = 32'(FILL_LIMIT_RESET);
            overwrite = OVERWRITE_RESET;
            awaited_results.delete();
            results_seen = 0;
            pending      = 0;
            failures     = 0;
        end
        else
        begin
            // results come back through registers after their item, so compare before queuing
            if (done)
            begin
                results_seen = results_seen + 1;
                if (awaited_results.size() == 0)
                begin
                    if (failures < MAX_REPORTS)
                        $display("unexpected result %0d: data %h ok %b level %0d evicted %0d",
                                 results_seen, result.data, result.ok, result.level,
                                 result.evicted);
                    failures = failures + 1;
                end
                else
                begin
                    oldest = awaited_results.pop_front();
                    if (result.data !== oldest.data || result.ok !== oldest.ok ||
                        result.level !== oldest.level || result.evicted !== oldest.evicted)
                    begin
                        if (failures < MAX_REPORTS)
                        begin
                            $display("result %0d mismatch: expected data %h ok %b level %0d evicted %0d",
                                     results_seen, oldest.data, oldest.ok, oldest.level,
                                     oldest.evicted);
                            $display("    got data %h ok %b level %0d evicted %0d",
                                     result.data, result.ok, result.level, result.evicted);
                        end
                        failures = failures + 1;
                    end
                end
            end

            // register writes; unknown indexes are ignored
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_FILL_LIMIT)
                    limit = 32'(cfg_data);
                else if (cfg_index == CFG_OVERWRITE)
                    overwrite = cfg_data[0];
            end

            // accepted operation goes to the back of the owed list
            if (start && !busy)
                awaited_results.insert(awaited_results.size(), apply_queue_op(item));

            pending = awaited_results.size();
        end
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import bqo_pkg::*;

    // opcodes and register index with no function in the block
    localparam logic [OPCODE_BITS-1:0]    OP_SPARE_A = 3'd6;
    localparam logic [OPCODE_BITS-1:0]    OP_SPARE_B = 3'd7;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE  = 2'd3;

    localparam int RANDOM_PHASES   = 12;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 8;
    localparam logic [WORD_BITS-1:0] ALL_ONES = '1;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       start     = 1'b0;
    logic       busy;
    in_item_t   item      = '0;
    logic       done;
    out_item_t  result;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;
    int         pending;
    int         failures;

    // per-phase settings; the last two are drawn at run time
    int unsigned phase_limit [RANDOM_PHASES] = '{16, 16, 31, 17, 1, 0, 0, 2, 8, 31, 0, 0};
    logic        phase_ow    [RANDOM_PHASES] = '{0, 1, 1, 0, 1, 0, 1, 1, 0, 0, 0, 0};
    int unsigned phase_push  [RANDOM_PHASES] = '{55, 60, 70, 70, 50, 45, 45, 50, 55, 40, 0, 0};

    bounded_queue_with_overwrite DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    queue_checker queue_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pending   (pending),
        .failures  (failures)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // hand one operation to the block and wait until it is taken
    task automatic issue(input logic [OPCODE_BITS-1:0] op,
                         input logic [WORD_BITS-1:0]   w,
                         input logic [FIELD5_BITS-1:0] n);
        start <= 1'b1;
        item  <= {op, w, n};
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // stop issuing and wait until every owed result has come back
    task automatic wait_idle();
        start <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    // write the spare index, the fill limit and the overwrite flag
    task automatic program_queue(input logic [FIELD5_BITS-1:0] fill, input logic ow);
        logic [CFG_INDEX_BITS-1:0] idx [3];
        logic [CFG_DATA_BITS-1:0]  val [3];
        int                        k;
        idx[0] = CFG_SPARE;
        idx[1] = CFG_FILL_LIMIT;
        idx[2] = CFG_OVERWRITE;
        val[0] = CFG_DATA_BITS'($urandom);
        val[1] = fill;
        val[2] = {(CFG_DATA_BITS-1)'($urandom), ow};
        for (k = 0; k < 3; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // stall watchdog: any item, result or register write counts as progress
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // stimulus
    initial
    begin : stimulus
        int                     phase;
        int                     i;
        int                     gap;
        int                     burst_left;
        int                     roll;
        logic                   steady;
        logic [OPCODE_BITS-1:0] op;
        logic [WORD_BITS-1:0]   w;
        logic [FIELD5_BITS-1:0] n;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue under the reset settings, spare opcodes included
        issue(OP_POP_ONE, '0, '0);
        issue(OP_TRY_POP, ALL_ONES, '0);
        issue(OP_NEWEST, '0, '0);
        issue(OP_PEEK, '0, '0);
        issue(OP_POP_MANY, '0, '0);
        issue(OP_SPARE_A, ALL_ONES, 5'd31);
        issue(OP_SPARE_B, '0, '0);

        // two held words: hits, an out-of-range peek, bad and good pop many
        issue(OP_PUSH, '0, 5'd31);
        issue(OP_PUSH, ALL_ONES, '0);
        issue(OP_PEEK, '0, 5'd1);
        issue(OP_PEEK, ALL_ONES, 5'd31);
        issue(OP_NEWEST, '0, '0);
        issue(OP_POP_MANY, '0, 5'd31);
        issue(OP_POP_MANY, '0, 5'd2);

        // small limit with overwrite: third push evicts the oldest
        wait_idle();
        program_queue(5'd2, 1'b1);
        issue(OP_PUSH, 32'hA5A5_5A5A, '0);
        issue(OP_PUSH, 32'h5A5A_A5A5, '0);
        issue(OP_PUSH, $urandom, '0);
        issue(OP_TRY_POP, '0, '0);

        // zero limit: dropped word, then a flush
        wait_idle();
        program_queue(5'd0, 1'b0);
        issue(OP_PUSH, $urandom, '0);
        wait_idle();
        program_queue(5'd0, 1'b1);
        issue(OP_PUSH, $urandom, '0);

        // random phases, each under its own settings
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase >= RANDOM_PHASES - 2)
            begin
                phase_limit[phase] = $urandom_range(0, 31);
                phase_ow[phase]    = 1'($urandom_range(0, 1));
                phase_push[phase]  = $urandom_range(35, 75);
            end
            wait_idle();
            program_queue(FIELD5_BITS'(phase_limit[phase]), phase_ow[phase]);
            steady     = ($urandom_range(0, 3) == 0);
            burst_left = 0;
            for (i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                // bursts separated by random gaps, unless this phase runs flat out
                if (burst_left == 0)
                begin
                    gap = steady ? 0 : $urandom_range(0, 8);
                    if (gap > 0)
                    begin
                        start <= 1'b0;
                        repeat (gap) @(posedge clk);
                    end
                    burst_left = $urandom_range(1, 40);
                end
                burst_left = burst_left - 1;

                // operation mix weighted toward pushes so the queue fills
                roll = $urandom_range(0, 99);
                if (roll < phase_push[phase])
                    op = OP_PUSH;
                else if (roll >= 97)
                    op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
                else
                begin
                    case ($urandom_range(0, 4))
                        0:       op = OP_POP_ONE;
                        1:       op = OP_POP_MANY;
                        2:       op = OP_PEEK;
                        3:       op = OP_TRY_POP;
                        default: op = OP_NEWEST;
                    endcase
                end

                case ($urandom_range(0, 15))
                    0:       w = '0;
                    1:       w = ALL_ONES;
                    default: w = $urandom;
                endcase

                // mostly counts near the held range, sometimes the full field
                if ($urandom_range(0, 4) == 0)
                    n = FIELD5_BITS'($urandom_range(0, 31));
                else
                    n = FIELD5_BITS'($urandom_range(0, 17));

                issue(op, w, n);
            end
        end

        // drain and give any stray result time to show up
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (failures == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### files.f
hdl/bqo_pkg.sv
hdl/bqo_ram.sv
hdl/bqo_core.sv
hdl/bounded_queue_with_overwrite.sv
tb/queue_checker.sv
tb/testbench.sv
